>>> design/vdp_pkg.sv
// shared types, constants and a function of the video display port interface
package vdp_pkg;

    localparam int VRAM_DEPTH = 16384;
    localparam int ADDR_W     = 14;
    localparam int ADDR_SPAN  = 1 << ADDR_W;
    localparam int RAM_AW     = $clog2(VRAM_DEPTH);
    localparam int RED_STEPS  = $clog2((ADDR_SPAN + VRAM_DEPTH - 1) / VRAM_DEPTH);

    localparam logic ACC_WRITE = 1'b0;
    localparam logic ACC_READ  = 1'b1;
    localparam logic PORT_DATA = 1'b0;
    localparam logic PORT_CTRL = 1'b1;

    localparam logic [1:0] CMD_READ_ADDR  = 2'b00;
    localparam logic [1:0] CMD_WRITE_ADDR = 2'b01;
    localparam logic [1:0] CMD_REG        = 2'b10;
    localparam logic [1:0] CMD_LATCH_CLR  = 2'b11;

    localparam logic [2:0] REG_MODE0       = 3'd0;
    localparam logic [2:0] REG_MODE1       = 3'd1;
    localparam logic [2:0] REG_NAME        = 3'd2;
    localparam logic [2:0] REG_COLOR       = 3'd3;
    localparam logic [2:0] REG_PATTERN     = 3'd4;
    localparam logic [2:0] REG_SPRITE_ATTR = 3'd5;
    localparam logic [2:0] REG_SPRITE_PAT  = 3'd6;
    localparam logic [2:0] REG_TEXT_COLORS = 3'd7;

    localparam logic [4:0] MODE_RESET     = 5'd7;
    localparam logic [4:0] MODE_GRAPHICS2 = 5'd4;
    localparam logic [4:0] FLAGS_RESET    = 5'h1c;
    localparam logic [ADDR_W-1:0] SPLIT_BASE = 14'h2000;

    typedef enum logic {
        ST_CLEAR,
        ST_RUN
    } vdp_state_t;

    typedef struct packed {
        logic [4:0]        display_mode;
        logic [4:0]        control_flags;
        logic [ADDR_W-1:0] name_base;
        logic [ADDR_W-1:0] color_base;
        logic [ADDR_W-1:0] pattern_base;
        logic [ADDR_W-1:0] sprite_attr_base;
        logic [ADDR_W-1:0] sprite_pattern_base;
        logic [7:0]        text_colors;
        logic [1:0]        pattern_split;
        logic [1:0]        color_split;
    } vdp_cfg_t;

    typedef struct packed {
        logic              en;
        logic              we;
        logic [ADDR_W-1:0] ptr;
        logic [7:0]        data;
    } vdp_ram_req_t;

    // pointer modulo the memory depth by restoring compare and subtract
    function automatic logic [RAM_AW-1:0] ram_index(input logic [ADDR_W-1:0] p);
        logic [ADDR_W:0] r;
        r = {1'b0, p};
        for (int i = RED_STEPS - 1; i >= 0; i--) begin
            if (r >= ((ADDR_W + 1)'(VRAM_DEPTH) << i)) begin
                r = r - ((ADDR_W + 1)'(VRAM_DEPTH) << i);
            end
        end
        return r[RAM_AW-1:0];
    endfunction

endpackage

>>> design/video_display_port_interface_unit.sv
// top level of the video display port interface
// Each bus access is one transfer in and one result transfer out; a new access is
// taken every cycle as long as the previous result is taken, and the result appears
// the cycle after the access, in step with the registered read of the video ram.
// After reset the block sweeps all VRAM_DEPTH bytes (16384 by default) of the video
// ram to zero, one byte per cycle, and s_ready stays low during the sweep.
module video_display_port_interface_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_mode,
    input  logic        s_port_select,
    input  logic [7:0]  s_data_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_read_data,
    output logic [4:0]  m_display_mode,
    output logic [4:0]  m_control_flags,
    output logic [13:0] m_name_base,
    output logic [13:0] m_color_base,
    output logic [13:0] m_pattern_base,
    output logic [13:0] m_sprite_attr_base,
    output logic [13:0] m_sprite_pattern_base,
    output logic [7:0]  m_text_colors,
    output logic [1:0]  m_pattern_split,
    output logic [1:0]  m_color_split
);

    localparam logic [vdp_pkg::RAM_AW-1:0] CLR_LAST = vdp_pkg::RAM_AW'(vdp_pkg::VRAM_DEPTH - 1);

    vdp_pkg::vdp_state_t         state_reg, state_next;
    logic [vdp_pkg::RAM_AW-1:0]  clr_cnt_reg, clr_cnt_next;
    logic                        pend_reg, pend_next;
    logic                        rd_sel_reg, rd_sel_next;
    logic                        accept;
    logic                        ram_en, ram_we;
    logic [vdp_pkg::RAM_AW-1:0]  ram_addr;
    logic [7:0]                  ram_wdata, ram_rdata;
    vdp_pkg::vdp_cfg_t           cfg;
    vdp_pkg::vdp_ram_req_t       ram_req;

    assign accept = s_valid && s_ready;

    vdp_regs u_regs (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .accept      (accept),
        .mode        (s_mode),
        .port_select (s_port_select),
        .data_byte   (s_data_byte),
        .cfg         (cfg),
        .ram_req     (ram_req)
    );

    vdp_ram #(
        .WIDTH (8),
        .DEPTH (vdp_pkg::VRAM_DEPTH)
    ) u_vram (
        .aclk  (aclk),
        .en    (ram_en),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    always_comb begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        s_ready      = 1'b0;
        ram_en       = 1'b0;
        ram_we       = 1'b0;
        ram_addr     = '0;
        ram_wdata    = '0;
        case (state_reg)
            vdp_pkg::ST_CLEAR: begin
                ram_en       = 1'b1;
                ram_we       = 1'b1;
                ram_addr     = clr_cnt_reg;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == CLR_LAST) begin
                    state_next = vdp_pkg::ST_RUN;
                end
            end
            vdp_pkg::ST_RUN: begin
                s_ready   = !pend_reg || m_ready;
                ram_en    = ram_req.en && s_valid && s_ready;
                ram_we    = ram_req.we;
                ram_addr  = vdp_pkg::ram_index(ram_req.ptr);
                ram_wdata = ram_req.data;
            end
            default: begin
                state_next = vdp_pkg::ST_CLEAR;
            end
        endcase
    end

    always_comb begin
        pend_next   = pend_reg;
        rd_sel_next = rd_sel_reg;
        if (accept) begin
            pend_next   = 1'b1;
            rd_sel_next = (s_mode == vdp_pkg::ACC_READ) && (s_port_select == vdp_pkg::PORT_DATA);
        end else if (m_ready) begin
            pend_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= vdp_pkg::ST_CLEAR;
            clr_cnt_reg <= '0;
            pend_reg    <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            pend_reg    <= pend_next;
        end
    end

    always_ff @(posedge aclk) begin
        rd_sel_reg <= rd_sel_next;
    end

    // config outputs show the live state, which holds until the next transfer in
    assign m_valid               = pend_reg;
    assign m_read_data           = rd_sel_reg ? ram_rdata : 8'h00;
    assign m_display_mode        = cfg.display_mode;
    assign m_control_flags       = cfg.control_flags;
    assign m_name_base           = cfg.name_base;
    assign m_color_base          = cfg.color_base;
    assign m_pattern_base        = cfg.pattern_base;
    assign m_sprite_attr_base    = cfg.sprite_attr_base;
    assign m_sprite_pattern_base = cfg.sprite_pattern_base;
    assign m_text_colors         = cfg.text_colors;
    assign m_pattern_split       = cfg.pattern_split;
    assign m_color_split         = cfg.color_split;

endmodule

>>> design/vdp_ram.sv
// generic single-port ram with registered read
module vdp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (en) begin
            if (we) begin
                mem[addr] <= wdata;
            end else begin
                rdata <= mem[addr];
            end
        end
    end

endmodule

>>> design/vdp_regs.sv
// access decoder: pointers, control byte latch and display registers
module vdp_regs (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  accept,
    input  logic                  mode,
    input  logic                  port_select,
    input  logic [7:0]            data_byte,
    output vdp_pkg::vdp_cfg_t     cfg,
    output vdp_pkg::vdp_ram_req_t ram_req
);

    logic [vdp_pkg::ADDR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [vdp_pkg::ADDR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic                       pending_reg, pending_next;
    logic [7:0]                 held_reg, held_next;
    vdp_pkg::vdp_cfg_t          cfg_reg, cfg_next;
    logic [vdp_pkg::ADDR_W-1:0] addr_word;

    assign addr_word = {data_byte[5:0], held_reg};
    assign cfg       = cfg_reg;

    always_comb begin
        ram_req.en   = (port_select == vdp_pkg::PORT_DATA);
        ram_req.we   = (mode == vdp_pkg::ACC_WRITE);
        ram_req.ptr  = (mode == vdp_pkg::ACC_WRITE) ? wr_ptr_reg : rd_ptr_reg;
        ram_req.data = data_byte;
    end

    always_comb begin
        wr_ptr_next  = wr_ptr_reg;
        rd_ptr_next  = rd_ptr_reg;
        pending_next = pending_reg;
        held_next    = held_reg;
        cfg_next     = cfg_reg;
        if (accept) begin
            if (port_select == vdp_pkg::PORT_DATA) begin
                if (mode == vdp_pkg::ACC_WRITE) begin
                    wr_ptr_next = wr_ptr_reg + 1'b1;
                end else begin
                    rd_ptr_next = rd_ptr_reg + 1'b1;
                end
            end else if (mode == vdp_pkg::ACC_WRITE) begin
                if (!pending_reg) begin
                    pending_next = 1'b1;
                    held_next    = data_byte;
                end else begin
                    pending_next = 1'b0;
                    case (data_byte[7:6])
                        vdp_pkg::CMD_REG: begin
                            case (data_byte[2:0])
                                vdp_pkg::REG_MODE0: begin
                                    cfg_next.display_mode[4:2] = held_reg[3:1];
                                end
                                vdp_pkg::REG_MODE1: begin
                                    cfg_next.display_mode[0] = held_reg[4];
                                    cfg_next.display_mode[1] = held_reg[3];
                                    cfg_next.control_flags   = {held_reg[7:5], held_reg[1:0]};
                                end
                                vdp_pkg::REG_NAME: begin
                                    cfg_next.name_base = {held_reg[3:0], 10'b0};
                                end
                                vdp_pkg::REG_COLOR: begin
                                    cfg_next.color_split = held_reg[6:5];
                                    if (cfg_reg.display_mode != vdp_pkg::MODE_GRAPHICS2) begin
                                        cfg_next.color_base = {held_reg, 6'b0};
                                    end else begin
                                        cfg_next.color_base =
                                            held_reg[7] ? vdp_pkg::SPLIT_BASE : '0;
                                    end
                                end
                                vdp_pkg::REG_PATTERN: begin
                                    cfg_next.pattern_split = held_reg[1:0];
                                    if (cfg_reg.display_mode != vdp_pkg::MODE_GRAPHICS2) begin
                                        cfg_next.pattern_base = {held_reg[2:0], 11'b0};
                                    end else begin
                                        cfg_next.pattern_base =
                                            held_reg[2] ? vdp_pkg::SPLIT_BASE : '0;
                                    end
                                end
                                vdp_pkg::REG_SPRITE_ATTR: begin
                                    cfg_next.sprite_attr_base = {held_reg[6:0], 7'b0};
                                end
                                vdp_pkg::REG_SPRITE_PAT: begin
                                    cfg_next.sprite_pattern_base = {held_reg[2:0], 11'b0};
                                end
                                vdp_pkg::REG_TEXT_COLORS: begin
                                    cfg_next.text_colors = held_reg;
                                end
                                default: begin
                                end
                            endcase
                        end
                        vdp_pkg::CMD_WRITE_ADDR: begin
                            wr_ptr_next = addr_word;
                        end
                        vdp_pkg::CMD_READ_ADDR: begin
                            rd_ptr_next = addr_word;
                        end
                        vdp_pkg::CMD_LATCH_CLR: begin
                        end
                        default: begin
                        end
                    endcase
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg  <= '0;
            rd_ptr_reg  <= '0;
            pending_reg <= 1'b0;
            held_reg    <= '0;
            cfg_reg     <= '{display_mode:  vdp_pkg::MODE_RESET,
                             control_flags: vdp_pkg::FLAGS_RESET,
                             default:       '0};
        end else begin
            wr_ptr_reg  <= wr_ptr_next;
            rd_ptr_reg  <= rd_ptr_next;
            pending_reg <= pending_next;
            held_reg    <= held_next;
            cfg_reg     <= cfg_next;
        end
    end

endmodule

>>> design/vdp_checker.sv
// port-level assertions for the video display port interface, bound to the top level
module vdp_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        s_mode,
    input logic        s_port_select,
    input logic        m_valid,
    input logic        m_ready,
    input logic [7:0]  m_read_data,
    input logic [13:0] m_name_base
);

    // no transfer in right after reset, at the start of the ram sweep
    a_clear_blocks: assert property (@(posedge aclk)
        !aresetn |=> !s_ready)
        else $error("input ready right after reset");

    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> m_valid)
        else $error("no result after an input transfer");

    a_stall_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |-> !s_ready)
        else $error("input taken while a result is stalled");

    a_write_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && (!s_mode || s_port_select)) |=> (m_read_data == 8'h00))
        else $error("write or status access returned nonzero read data");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_read_data) && $stable(m_name_base)))
        else $error("stalled result changed");

endmodule

bind video_display_port_interface_unit vdp_checker u_vdp_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .s_mode        (s_mode),
    .s_port_select (s_port_select),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_read_data   (m_read_data),
    .m_name_base   (m_name_base)
);

>>> tb/video_display_port_interface_unit_tb.sv
// self-checking testbench for the video display port interface: bus accesses in, state views out
`timescale 1ns / 100ps

module video_display_port_interface_unit_tb;

    typedef struct {
        logic       acc;
        logic       port;
        logic [7:0] data;
    } bus_access_t;

    typedef struct packed {
        logic [7:0]         read_data;
        vdp_pkg::vdp_cfg_t  cfg;
    } port_view_t;

    localparam int RANDOM_ACCESSES = 1700;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic        s_mode = vdp_pkg::ACC_WRITE;
    logic        s_port_select = vdp_pkg::PORT_DATA;
    logic [7:0]  s_data_byte = 8'h00;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [7:0]  m_read_data;
    logic [4:0]  m_display_mode;
    logic [4:0]  m_control_flags;
    logic [13:0] m_name_base;
    logic [13:0] m_color_base;
    logic [13:0] m_pattern_base;
    logic [13:0] m_sprite_attr_base;
    logic [13:0] m_sprite_pattern_base;
    logic [7:0]  m_text_colors;
    logic [1:0]  m_pattern_split;
    logic [1:0]  m_color_split;

    video_display_port_interface_unit dut (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .s_valid              (s_valid),
        .s_ready              (s_ready),
        .s_mode               (s_mode),
        .s_port_select        (s_port_select),
        .s_data_byte          (s_data_byte),
        .m_valid              (m_valid),
        .m_ready              (m_ready),
        .m_read_data          (m_read_data),
        .m_display_mode       (m_display_mode),
        .m_control_flags      (m_control_flags),
        .m_name_base          (m_name_base),
        .m_color_base         (m_color_base),
        .m_pattern_base       (m_pattern_base),
        .m_sprite_attr_base   (m_sprite_attr_base),
        .m_sprite_pattern_base(m_sprite_pattern_base),
        .m_text_colors        (m_text_colors),
        .m_pattern_split      (m_pattern_split),
        .m_color_split        (m_color_split)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    bus_access_t bus_accesses[$];
    port_view_t  expected_views[$];
    int          total_accesses = 0;
    int          accepted = 0;
    int          results_seen = 0;
    int          mismatches = 0;

    // shadow of the block state
    logic [7:0]                 vram_image [vdp_pkg::VRAM_DEPTH] = '{default: 8'h00};
    logic [vdp_pkg::ADDR_W-1:0] wr_ptr = '0;
    logic [vdp_pkg::ADDR_W-1:0] rd_ptr = '0;
    logic                       latch_full = 1'b0;
    logic [7:0]                 latch_byte = 8'h00;
    logic [4:0]                 mode_q = vdp_pkg::MODE_RESET;
    logic [4:0]                 flags_q = vdp_pkg::FLAGS_RESET;
    logic [vdp_pkg::ADDR_W-1:0] name_q = '0;
    logic [vdp_pkg::ADDR_W-1:0] color_q = '0;
    logic [vdp_pkg::ADDR_W-1:0] pattern_q = '0;
    logic [vdp_pkg::ADDR_W-1:0] sprite_attr_q = '0;
    logic [vdp_pkg::ADDR_W-1:0] sprite_pat_q = '0;
    logic [7:0]                 raw_regs [8] = '{default: 8'h00};

    int n_data_wr = 0;
    int n_data_rd = 0;
    int n_status = 0;
    int n_reg_wr = 0;
    int n_ptr_load = 0;
    int n_latch_clr = 0;
    int n_split = 0;

    // stimulus side tracking of the control latch
    logic gen_latch = 1'b0;

    task automatic load_register(input logic [2:0] r, input logic [7:0] d);
        raw_regs[r] = d;
        n_reg_wr++;
        case (r)
            vdp_pkg::REG_MODE0: begin
                mode_q = {d[3:1], mode_q[1:0]};
            end
            vdp_pkg::REG_MODE1: begin
                mode_q  = {mode_q[4:2], d[3], d[4]};
                flags_q = {d[7:5], d[1:0]};
            end
            vdp_pkg::REG_NAME: begin
                name_q = vdp_pkg::ADDR_W'({d, 10'b0});
            end
            vdp_pkg::REG_COLOR: begin
                if (mode_q == vdp_pkg::MODE_GRAPHICS2) begin
                    color_q = d[7] ? vdp_pkg::SPLIT_BASE : '0;
                    n_split++;
                end else begin
                    color_q = vdp_pkg::ADDR_W'({d, 6'b0});
                end
            end
            vdp_pkg::REG_PATTERN: begin
                if (mode_q == vdp_pkg::MODE_GRAPHICS2) begin
                    pattern_q = d[2] ? vdp_pkg::SPLIT_BASE : '0;
                    n_split++;
                end else begin
                    pattern_q = vdp_pkg::ADDR_W'({d, 11'b0});
                end
            end
            vdp_pkg::REG_SPRITE_ATTR: begin
                sprite_attr_q = vdp_pkg::ADDR_W'({d, 7'b0});
            end
            vdp_pkg::REG_SPRITE_PAT: begin
                sprite_pat_q = vdp_pkg::ADDR_W'({d, 11'b0});
            end
            default: begin
            end
        endcase
    endtask

    task automatic predict_access(input logic acc, input logic port, input logic [7:0] v);
        port_view_t                 view;
        logic [vdp_pkg::ADDR_W-1:0] addr;
        view.read_data = 8'h00;
        addr = {v[5:0], latch_byte};
        if (acc == vdp_pkg::ACC_READ) begin
            if (port == vdp_pkg::PORT_DATA) begin
                view.read_data =
                    vram_image[vdp_pkg::RAM_AW'(rd_ptr % vdp_pkg::VRAM_DEPTH)];
                rd_ptr = rd_ptr + 1'b1;
                n_data_rd++;
            end else begin
                n_status++;
            end
        end else if (port == vdp_pkg::PORT_DATA) begin
            vram_image[vdp_pkg::RAM_AW'(wr_ptr % vdp_pkg::VRAM_DEPTH)] = v;
            wr_ptr = wr_ptr + 1'b1;
            n_data_wr++;
        end else if (!latch_full) begin
            latch_full = 1'b1;
            latch_byte = v;
        end else begin
            latch_full = 1'b0;
            case (v[7:6])
                vdp_pkg::CMD_REG: begin
                    load_register(v[2:0], latch_byte);
                end
                vdp_pkg::CMD_WRITE_ADDR: begin
                    wr_ptr = addr;
                    n_ptr_load++;
                end
                vdp_pkg::CMD_READ_ADDR: begin
                    rd_ptr = addr;
                    n_ptr_load++;
                end
                default: begin
                    n_latch_clr++;
                end
            endcase
        end
        view.cfg.display_mode        = mode_q;
        view.cfg.control_flags       = flags_q;
        view.cfg.name_base           = name_q;
        view.cfg.color_base          = color_q;
        view.cfg.pattern_base        = pattern_q;
        view.cfg.sprite_attr_base    = sprite_attr_q;
        view.cfg.sprite_pattern_base = sprite_pat_q;
        view.cfg.text_colors         = raw_regs[vdp_pkg::REG_TEXT_COLORS];
        view.cfg.pattern_split       = raw_regs[vdp_pkg::REG_PATTERN][1:0];
        view.cfg.color_split         = raw_regs[vdp_pkg::REG_COLOR][6:5];
        expected_views.push_back(view);
    endtask

    task automatic push_access(input logic acc, input logic port, input logic [7:0] d);
        bus_access_t a;
        a.acc  = acc;
        a.port = port;
        a.data = d;
        bus_accesses.push_back(a);
        if (acc == vdp_pkg::ACC_WRITE && port == vdp_pkg::PORT_CTRL) begin
            gen_latch = ~gen_latch;
        end
    endtask

    task automatic push_ctrl(input logic [7:0] d);
        push_access(vdp_pkg::ACC_WRITE, vdp_pkg::PORT_CTRL, d);
    endtask

    // a half-written command is closed by a latch clear byte
    task automatic resync_latch();
        if (gen_latch) begin
            push_ctrl({vdp_pkg::CMD_LATCH_CLR, 6'($urandom)});
        end
    endtask

    task automatic set_pointer(input logic [1:0] cmd, input logic [vdp_pkg::ADDR_W-1:0] addr);
        resync_latch();
        push_ctrl(addr[7:0]);
        push_ctrl({cmd, addr[13:8]});
    endtask

    task automatic queue_reg_write(input logic [2:0] r, input logic [7:0] d);
        resync_latch();
        push_ctrl(d);
        push_ctrl({vdp_pkg::CMD_REG, 3'($urandom), r});
    endtask

    function automatic logic [vdp_pkg::ADDR_W-1:0] pick_addr();
        if ($urandom_range(0, 1) == 0) begin
            return vdp_pkg::ADDR_W'($urandom);
        end
        return vdp_pkg::ADDR_W'($urandom_range(0, 63)) +
               ($urandom_range(0, 1) ? 14'h3fc0 : 14'h0000);
    endfunction

    function automatic int idle_phase();
        int p;
        p = (total_accesses > 0) ? (accepted * 4) / total_accesses : 0;
        return (p > 3) ? 3 : p;
    endfunction

    function automatic bit sender_idle();
        case (idle_phase())
            1: return $urandom_range(0, 99) < 59;
            3: return $urandom_range(0, 99) < 16;
            default: return 1'b0;
        endcase
    endfunction

    function automatic bit receiver_stall();
        case (idle_phase())
            2: return $urandom_range(0, 99) < 59;
            3: return $urandom_range(0, 99) < 16;
            default: return 1'b0;
        endcase
    endfunction

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("mismatch on result %0d: %s expected 0x%0h, got 0x%0h",
                         results_seen, name, want, got);
            end
        end
    endfunction

    // driver
    always @(posedge aclk) begin
        bus_access_t a;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                predict_access(s_mode, s_port_select, s_data_byte);
                accepted++;
            end
            if (!s_valid || s_ready) begin
                if (bus_accesses.size() > 0 && !sender_idle()) begin
                    a = bus_accesses.pop_front();
                    s_valid       <= 1'b1;
                    s_mode        <= a.acc;
                    s_port_select <= a.port;
                    s_data_byte   <= a.data;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        port_view_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                results_seen++;
                if (expected_views.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("unexpected result transfer %0d", results_seen);
                    end
                end else begin
                    want = expected_views.pop_front();
                    check_field("read_data", 32'(want.read_data), 32'(m_read_data));
                    check_field("display_mode", 32'(want.cfg.display_mode),
                                32'(m_display_mode));
                    check_field("control_flags", 32'(want.cfg.control_flags),
                                32'(m_control_flags));
                    check_field("name_base", 32'(want.cfg.name_base), 32'(m_name_base));
                    check_field("color_base", 32'(want.cfg.color_base), 32'(m_color_base));
                    check_field("pattern_base", 32'(want.cfg.pattern_base),
                                32'(m_pattern_base));
                    check_field("sprite_attr_base", 32'(want.cfg.sprite_attr_base),
                                32'(m_sprite_attr_base));
                    check_field("sprite_pattern_base", 32'(want.cfg.sprite_pattern_base),
                                32'(m_sprite_pattern_base));
                    check_field("text_colors", 32'(want.cfg.text_colors),
                                32'(m_text_colors));
                    check_field("pattern_split", 32'(want.cfg.pattern_split),
                                32'(m_pattern_split));
                    check_field("color_split", 32'(want.cfg.color_split),
                                32'(m_color_split));
                end
            end
            m_ready <= !receiver_stall();
        end
    end

    initial begin
        int                         kind;
        int                         target;
        logic [vdp_pkg::ADDR_W-1:0] last_wr;
        last_wr = '0;

        // directed part
        push_access(vdp_pkg::ACC_READ, vdp_pkg::PORT_CTRL, 8'h00);
        push_ctrl(8'hff);
        push_ctrl({vdp_pkg::CMD_REG, 3'b111, vdp_pkg::REG_TEXT_COLORS});
        set_pointer(vdp_pkg::CMD_WRITE_ADDR, 14'h3fff);
        push_access(vdp_pkg::ACC_WRITE, vdp_pkg::PORT_DATA, 8'hff);
        push_access(vdp_pkg::ACC_WRITE, vdp_pkg::PORT_DATA, 8'h5a);
        set_pointer(vdp_pkg::CMD_READ_ADDR, 14'h3fff);
        push_access(vdp_pkg::ACC_READ, vdp_pkg::PORT_DATA, 8'h00);
        push_access(vdp_pkg::ACC_READ, vdp_pkg::PORT_DATA, 8'hff);
        push_ctrl(8'h12);
        push_ctrl({vdp_pkg::CMD_LATCH_CLR, 6'h00});
        push_ctrl(8'hff);
        push_access(vdp_pkg::ACC_READ, vdp_pkg::PORT_CTRL, 8'h55);
        push_access(vdp_pkg::ACC_READ, vdp_pkg::PORT_DATA, 8'haa);
        push_ctrl({vdp_pkg::CMD_REG, 3'b000, vdp_pkg::REG_NAME});
        queue_reg_write(vdp_pkg::REG_MODE1, 8'h00);
        queue_reg_write(vdp_pkg::REG_MODE0, 8'h02);
        queue_reg_write(vdp_pkg::REG_COLOR, 8'h80);
        queue_reg_write(vdp_pkg::REG_PATTERN, 8'h04);

        // random part, mostly well-formed command sequences
        target = bus_accesses.size() + RANDOM_ACCESSES;
        while (bus_accesses.size() < target) begin
            kind = $urandom_range(0, 99);
            if (kind < 25) begin
                queue_reg_write(3'($urandom), 8'($urandom));
            end else if (kind < 33) begin
                queue_reg_write(vdp_pkg::REG_MODE1, 8'($urandom) & 8'he7);
                queue_reg_write(vdp_pkg::REG_MODE0, (8'($urandom) & 8'hf1) | 8'h02);
            end else if (kind < 53) begin
                last_wr = pick_addr();
                set_pointer(vdp_pkg::CMD_WRITE_ADDR, last_wr);
                repeat ($urandom_range(1, 8))
                    push_access(vdp_pkg::ACC_WRITE, vdp_pkg::PORT_DATA, 8'($urandom));
            end else if (kind < 73) begin
                set_pointer(vdp_pkg::CMD_READ_ADDR,
                            ($urandom_range(0, 99) < 40) ? last_wr : pick_addr());
                repeat ($urandom_range(1, 8))
                    push_access(vdp_pkg::ACC_READ, vdp_pkg::PORT_DATA, 8'($urandom));
            end else if (kind < 80) begin
                repeat ($urandom_range(1, 4))
                    push_access(1'($urandom), vdp_pkg::PORT_DATA, 8'($urandom));
            end else if (kind < 88) begin
                push_access(1'($urandom), 1'($urandom), 8'($urandom));
            end else if (kind < 94) begin
                push_ctrl(8'($urandom));
                push_ctrl({vdp_pkg::CMD_LATCH_CLR, 6'($urandom)});
            end else begin
                push_access(vdp_pkg::ACC_READ, vdp_pkg::PORT_CTRL, 8'($urandom));
            end
        end
        total_accesses = bus_accesses.size();

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        while (accepted < total_accesses) @(posedge aclk);
        while (expected_views.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);

        $display("%0d accesses: %0d data writes, %0d data reads, %0d status reads",
                 accepted, n_data_wr, n_data_rd, n_status);
        $display("%0d register loads (%0d graphics II bases), %0d pointer loads, %0d latch clears",
                 n_reg_wr, n_split, n_ptr_load, n_latch_clr);
        if (mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("timeout with %0d of %0d accesses taken", accepted, total_accesses);
        $display("Regression FAIL");
        $finish;
    end

endmodule
